>>> hw/rtl/bdp_pkg.sv
// Shared types, constants and helpers for the box difference block.
package bdp_pkg;

  localparam int Dimensions  = 3;
  localparam int IndexWidth  = 32;
  localparam int MaxDims     = 3;
  localparam int FieldWidth  = 32;
  localparam int CoordWidth  = (IndexWidth > FieldWidth) ? FieldWidth : IndexWidth;
  localparam int SextShift   = FieldWidth - CoordWidth;
  localparam int MaskWidth   = 2 * MaxDims;
  localparam int QueueDepth  = 2;
  localparam int QueuePtrW   = $clog2(QueueDepth);
  localparam int QueueCountW = $clog2(QueueDepth + 1);

  typedef logic signed [FieldWidth-1:0] coord_t;

  typedef struct packed {
    coord_t a_lo_0;
    coord_t a_hi_0;
    coord_t a_lo_1;
    coord_t a_hi_1;
    coord_t a_lo_2;
    coord_t a_hi_2;
    coord_t b_lo_0;
    coord_t b_hi_0;
    coord_t b_lo_1;
    coord_t b_hi_1;
    coord_t b_lo_2;
    coord_t b_hi_2;
  } in_item_t;

  typedef struct packed {
    coord_t piece_lo_0;
    coord_t piece_hi_0;
    coord_t piece_lo_1;
    coord_t piece_hi_1;
    coord_t piece_lo_2;
    coord_t piece_hi_2;
    logic   piece_valid;
    logic   last_piece;
  } out_item_t;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_SPLIT,
    KIND_EMPTY
  } kind_t;

  typedef struct packed {
    kind_t                                kind;
    logic [MaskWidth-1:0]                 mask;
    logic [MaxDims-1:0][FieldWidth-1:0]   a_lo;
    logic [MaxDims-1:0][FieldWidth-1:0]   a_hi;
    logic [MaxDims-1:0][FieldWidth-1:0]   i_lo;
    logic [MaxDims-1:0][FieldWidth-1:0]   i_hi;
  } entry_t;

  function automatic coord_t sext(input logic [FieldWidth-1:0] v);
    coord_t t;
    t = coord_t'(v << SextShift);
    return t >>> SextShift;
  endfunction

endpackage

>>> hw/rtl/bdp_front.sv
// Front end: sign-extends the boxes, tests overlap and builds the piece mask.
module bdp_front (
  input  bdp_pkg::in_item_t boxes,
  output bdp_pkg::entry_t   entry
);
  import bdp_pkg::*;

  coord_t alo [MaxDims];
  coord_t ahi [MaxDims];
  coord_t blo [MaxDims];
  coord_t bhi [MaxDims];
  logic [MaxDims-1:0]   overlap;
  logic [MaskWidth-1:0] mask;

  always_comb begin
    alo[0] = sext(boxes.a_lo_0);
    ahi[0] = sext(boxes.a_hi_0);
    blo[0] = sext(boxes.b_lo_0);
    bhi[0] = sext(boxes.b_hi_0);
    alo[1] = sext(boxes.a_lo_1);
    ahi[1] = sext(boxes.a_hi_1);
    blo[1] = sext(boxes.b_lo_1);
    bhi[1] = sext(boxes.b_hi_1);
    alo[2] = sext(boxes.a_lo_2);
    ahi[2] = sext(boxes.a_hi_2);
    blo[2] = sext(boxes.b_lo_2);
    bhi[2] = sext(boxes.b_hi_2);
    for (int d = 0; d < MaxDims; d++) begin
      if (d >= Dimensions) begin
        alo[d] = coord_t'(0);
        ahi[d] = coord_t'(1);
        blo[d] = coord_t'(0);
        bhi[d] = coord_t'(1);
      end
    end
  end

  always_comb begin
    entry = '0;
    for (int d = 0; d < MaxDims; d++) begin
      overlap[d]      = (alo[d] < bhi[d]) && (blo[d] < ahi[d]) &&
                        (alo[d] < ahi[d]) && (blo[d] < bhi[d]);
      mask[2*d]       = alo[d] < blo[d];
      mask[2*d+1]     = ahi[d] > bhi[d];
      entry.a_lo[d]   = alo[d];
      entry.a_hi[d]   = ahi[d];
      entry.i_lo[d]   = mask[2*d]   ? blo[d] : alo[d];
      entry.i_hi[d]   = mask[2*d+1] ? bhi[d] : ahi[d];
    end
    entry.mask = mask;
    if (!(&overlap)) begin
      entry.kind = KIND_PASS;
    end else if (mask == '0) begin
      entry.kind = KIND_EMPTY;
    end else begin
      entry.kind = KIND_SPLIT;
    end
  end

endmodule

>>> hw/rtl/bdp_queue.sv
// Short queue of classified items between front and back.
module bdp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  bdp_pkg::entry_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output logic            rd_valid,
  output bdp_pkg::entry_t rd_data
);
  import bdp_pkg::*;

  entry_t                 store [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr;
  logic [QueuePtrW-1:0]   rd_ptr;
  logic [QueueCountW-1:0] count;

  assign full     = (count == QueueCountW'(QueueDepth));
  assign rd_valid = (count != '0);
  assign rd_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QueueCountW'(wr_en) - QueueCountW'(rd_en);
    end
  end

endmodule

>>> hw/rtl/bdp_back.sv
// Back end: walks the head's piece mask, emits a piece per cycle unless stalled.
module bdp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  bdp_pkg::entry_t    head,
  output logic               head_pop,
  output logic               empty,
  input  logic               pop,
  output bdp_pkg::out_item_t piece
);
  import bdp_pkg::*;

  logic [MaskWidth-1:0] used;
  logic [MaskWidth-1:0] used_next;
  logic [MaskWidth-1:0] rem;
  logic [MaskWidth-1:0] sel;
  logic                 last;
  logic                 emit;
  logic                 out_valid;
  logic [MaxDims-1:0][FieldWidth-1:0] p_lo;
  logic [MaxDims-1:0][FieldWidth-1:0] p_hi;
  out_item_t            built;

  assign rem   = head.mask & ~used;
  assign sel   = rem & (~rem + 1'b1);
  assign emit  = head_valid && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    for (int d = 0; d < MaxDims; d++) begin
      if (sel[2*d]) begin
        p_lo[d] = head.a_lo[d];
        p_hi[d] = head.i_lo[d];
      end else if (sel[2*d+1]) begin
        p_lo[d] = head.i_hi[d];
        p_hi[d] = head.a_hi[d];
      end else if (|(sel >> (2*d + 2))) begin
        p_lo[d] = head.i_lo[d];
        p_hi[d] = head.i_hi[d];
      end else begin
        p_lo[d] = head.a_lo[d];
        p_hi[d] = head.a_hi[d];
      end
    end
  end

  always_comb begin
    built     = '0;
    last      = 1'b1;
    used_next = used;
    unique case (head.kind)
      KIND_PASS: begin
        built.piece_lo_0  = head.a_lo[0];
        built.piece_hi_0  = head.a_hi[0];
        built.piece_lo_1  = head.a_lo[1];
        built.piece_hi_1  = head.a_hi[1];
        built.piece_lo_2  = head.a_lo[2];
        built.piece_hi_2  = head.a_hi[2];
        built.piece_valid = 1'b1;
      end
      KIND_SPLIT: begin
        last              = ((rem & ~sel) == '0);
        built.piece_lo_0  = p_lo[0];
        built.piece_hi_0  = p_hi[0];
        built.piece_lo_1  = p_lo[1];
        built.piece_hi_1  = p_hi[1];
        built.piece_lo_2  = p_lo[2];
        built.piece_hi_2  = p_hi[2];
        built.piece_valid = 1'b1;
      end
      default: begin
        built.piece_valid = 1'b0;
      end
    endcase
    built.last_piece = last;
    if (emit) begin
      used_next = last ? '0 : (used | sel);
    end
  end

  assign head_pop = emit && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      used <= used_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      piece <= built;
    end
  end

endmodule

>>> hw/rtl/box_difference_pieces_top.sv
// Top level of the box difference block: front, queue and back.
//
//   channel   ports                    moves
//   input     push, full, boxes        one pair of boxes A and B per item
//   result    empty, pop, piece        one piece of A minus B (or none) per item
//
// One result item leaves per cycle while the result port is not stalled; a pair that
// splits stays in the back end until all its pieces (one to six) have left, and the
// single piece generator takes no new pair before it is through with the last one.
// An accepted pair goes into the queue, then its first piece into the output register.
// Reset clears the queue's pointers and the output valid flag; payload is not cleared.
// A stalled result port fills the two-entry queue and then raises full.
module box_difference_pieces_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  bdp_pkg::in_item_t  boxes,
  output logic               empty,
  input  logic               pop,
  output bdp_pkg::out_item_t piece
);
  import bdp_pkg::*;

  entry_t front_entry;
  entry_t head;
  logic   head_valid;
  logic   head_pop;
  logic   accept;

  assign accept = push && !full;

  bdp_front u_front (
    .boxes (boxes),
    .entry (front_entry)
  );

  bdp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (accept),
    .wr_data  (front_entry),
    .full     (full),
    .rd_en    (head_pop),
    .rd_valid (head_valid),
    .rd_data  (head)
  );

  bdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .piece      (piece)
  );

endmodule

>>> sim/tb_box_difference_pieces_top.sv
// Self-checking testbench for box_difference_pieces_top: random and directed box pairs.
`timescale 1ns / 100ps

module tb_box_difference_pieces_top;
  import bdp_pkg::*;

  localparam coord_t CMIN = 32'sh80000000;
  localparam coord_t CMAX = 32'sh7fffffff;
  localparam int QUIET_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 160;

  class piece_scoreboard;
    out_item_t expected_pieces[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function out_item_t make_piece(coord_t lo[3], coord_t hi[3], logic valid, logic last);
      out_item_t p;
      p.piece_lo_0 = lo[0];
      p.piece_hi_0 = hi[0];
      p.piece_lo_1 = lo[1];
      p.piece_hi_1 = hi[1];
      p.piece_lo_2 = lo[2];
      p.piece_hi_2 = hi[2];
      p.piece_valid = valid;
      p.last_piece = last;
      return p;
    endfunction

    function void note_pair(in_item_t pair);
      coord_t alo[3], ahi[3], blo[3], bhi[3], clo[3], chi[3];
      coord_t lo_d, hi_d;
      out_item_t run[$];
      out_item_t none;
      bit overlap;
      int d;
      alo = '{sext(pair.a_lo_0), sext(pair.a_lo_1), sext(pair.a_lo_2)};
      ahi = '{sext(pair.a_hi_0), sext(pair.a_hi_1), sext(pair.a_hi_2)};
      blo = '{sext(pair.b_lo_0), sext(pair.b_lo_1), sext(pair.b_lo_2)};
      bhi = '{sext(pair.b_hi_0), sext(pair.b_hi_1), sext(pair.b_hi_2)};
      overlap = 1'b1;
      for (d = 0; d < 3; d++) begin
        if (d >= Dimensions) begin
          alo[d] = 0;
          ahi[d] = 1;
          blo[d] = 0;
          bhi[d] = 1;
        end
        lo_d = (alo[d] > blo[d]) ? alo[d] : blo[d];
        hi_d = (ahi[d] < bhi[d]) ? ahi[d] : bhi[d];
        if (!(lo_d < hi_d)) overlap = 1'b0;
        clo[d] = alo[d];
        chi[d] = ahi[d];
      end
      if (!overlap) begin
        expected_pieces = {expected_pieces, make_piece(alo, ahi, 1'b1, 1'b1)};
        return;
      end
      for (d = 0; d < 3; d++) begin
        if (alo[d] < blo[d]) begin
          clo[d] = alo[d];
          chi[d] = blo[d];
          run = {run, make_piece(clo, chi, 1'b1, 1'b0)};
        end
        if (ahi[d] > bhi[d]) begin
          clo[d] = bhi[d];
          chi[d] = ahi[d];
          run = {run, make_piece(clo, chi, 1'b1, 1'b0)};
        end
        clo[d] = (alo[d] > blo[d]) ? alo[d] : blo[d];
        chi[d] = (ahi[d] < bhi[d]) ? ahi[d] : bhi[d];
      end
      if (run.size() == 0) begin
        none = '0;
        none.last_piece = 1'b1;
        expected_pieces = {expected_pieces, none};
      end else begin
        run[run.size()-1].last_piece = 1'b1;
        expected_pieces = {expected_pieces, run};
      end
    endfunction

    function void compare(string name, coord_t want, coord_t got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_piece(out_item_t got);
      out_item_t want;
      if (expected_pieces.size() == 0) begin
        $error("piece item with nothing pending: %p", got);
        errors++;
        return;
      end
      want = expected_pieces.pop_front();
      compare("piece_lo_0", want.piece_lo_0, got.piece_lo_0);
      compare("piece_hi_0", want.piece_hi_0, got.piece_hi_0);
      compare("piece_lo_1", want.piece_lo_1, got.piece_lo_1);
      compare("piece_hi_1", want.piece_hi_1, got.piece_hi_1);
      compare("piece_lo_2", want.piece_lo_2, got.piece_lo_2);
      compare("piece_hi_2", want.piece_hi_2, got.piece_hi_2);
      compare("piece_valid", coord_t'(want.piece_valid), coord_t'(got.piece_valid));
      compare("last_piece", coord_t'(want.last_piece), coord_t'(got.last_piece));
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  boxes = '0;
  logic      full;
  logic      empty;
  out_item_t piece;

  piece_scoreboard sb;
  int  send_idle = 24;
  int  recv_idle = 47;
  int  quiet_cycles = 0;
  bit  in_acc = 1'b0;
  bit  out_acc = 1'b0;

  box_difference_pieces_top i_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .boxes (boxes),
    .empty (empty),
    .pop   (pop),
    .piece (piece)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  // Sample handshakes mid-cycle; they take effect at the next rising edge.
  always @(negedge clk) begin
    if (!rst) begin
      in_acc = (push === 1'b1) && (full === 1'b0);
      out_acc = (pop === 1'b1) && (empty === 1'b0);
      if (in_acc) sb.note_pair(boxes);
      if (out_acc) sb.check_piece(piece);
      if (in_acc || out_acc) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task automatic send_item(input in_item_t pair);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    boxes <= pair;
    do @(posedge clk); while (!in_acc);
  endtask

  function automatic coord_t extreme_value();
    case ($urandom_range(6))
      0: return CMIN;
      1: return CMIN + 1;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return CMAX - 1;
      default: return CMAX;
    endcase
  endfunction

  function automatic in_item_t random_pair();
    coord_t al[3], ah[3], bl[3], bh[3];
    coord_t c;
    int mode;
    int d;
    mode = $urandom_range(9);
    for (d = 0; d < 3; d++) begin
      c = ($urandom_range(3) == 0) ? coord_t'($urandom) : coord_t'(0);
      case (mode)
        0: begin
          al[d] = $urandom;
          ah[d] = $urandom;
          bl[d] = $urandom;
          bh[d] = $urandom;
        end
        8: begin
          al[d] = extreme_value();
          ah[d] = extreme_value();
          bl[d] = extreme_value();
          bh[d] = extreme_value();
        end
        9: begin
          al[d] = c + $signed($urandom_range(16)) - 8;
          ah[d] = al[d] + $urandom_range(1, 16);
          bl[d] = al[d] - $urandom_range(0, 3);
          bh[d] = ah[d] + $urandom_range(0, 3);
        end
        default: begin
          al[d] = c + $signed($urandom_range(16)) - 8;
          ah[d] = al[d] + $urandom_range(1, 16);
          bl[d] = c + $signed($urandom_range(24)) - 12;
          bh[d] = bl[d] + $urandom_range(1, 20);
        end
      endcase
    end
    return '{al[0], ah[0], al[1], ah[1], al[2], ah[2],
             bl[0], bh[0], bl[1], bh[1], bl[2], bh[2]};
  endfunction

  initial begin
    int p;
    int i;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_item('{0, 4, 0, 4, 0, 4, 1, 3, 1, 3, 1, 3});
    send_item('{1, 3, 1, 3, 1, 3, 0, 4, 0, 4, 0, 4});
    send_item('{0, 4, 0, 4, 0, 4, 0, 4, 0, 4, 0, 4});
    send_item('{0, 4, 0, 4, 0, 4, 4, 8, 0, 4, 0, 4});
    send_item('{0, 4, 0, 4, 0, 4, 10, 12, -3, -1, 0, 1});
    send_item('{5, 5, 0, 4, 0, 4, 0, 9, 0, 9, 0, 9});
    send_item('{0, 4, 0, 4, 0, 4, 0, 4, 3, 1, 0, 4});
    send_item('{7, 2, 0, 4, 0, 4, 0, 9, 0, 9, 0, 9});
    send_item('{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 0, 1, 0, 1, 0, 1});
    send_item('{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX});
    send_item('{0, 1, 0, 1, 0, 1, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX});
    send_item('{-8, 8, -8, 8, -8, 8, -8, 2, -8, 8, -8, 8});
    send_item('{-8, 8, -8, 8, -8, 8, -2, 8, -8, 8, -8, 8});
    send_item('{-8, 8, -8, 8, -8, 8, -8, 8, -3, 3, -8, 8});
    send_item('{-8, 8, -8, 8, -8, 8, -8, 8, -8, 8, 5, 20});
    send_item('{CMAX - 1, CMAX, CMIN, CMIN + 1, 0, 1,
                CMIN, CMAX, CMIN, CMAX, CMIN, CMAX});
    send_item('{CMIN, CMAX, 0, 10, 0, 10, CMIN + 1, CMAX - 1, 2, 8, 10, 20});
    send_item('{CMIN, CMAX, 0, 10, 0, 10, CMIN + 1, CMAX - 1, 2, 8, 9, 20});
    send_item('{-1, 0, -1, 0, -1, 0, -1, 0, -1, 0, -1, 0});
    send_item('{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX});
    send_item('{-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1});

    for (p = 0; p < 3; p++) begin
      case (p)
        0: begin send_idle = 24; recv_idle = 47; end
        1: begin send_idle = 47; recv_idle = 24; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      for (i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (p == 0 && i == RANDOM_PER_PHASE / 2) begin
          // hold off until the block has drained
          push <= 1'b0;
          @(posedge clk);
          while (sb.expected_pieces.size() != 0) @(posedge clk);
        end
        send_item(random_pair());
      end
    end

    push <= 1'b0;
    while (sb.expected_pieces.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
